### design/audio_header_format_parser_top_defines.svh
// assertion helpers used by the bound checker file
`ifndef AUDIO_HEADER_FORMAT_PARSER_TOP_DEFINES_SVH
`define AUDIO_HEADER_FORMAT_PARSER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define AHFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define AHFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/ahfp_pkg.sv
`timescale 1ns / 1ps

package ahfp_pkg;

  // byte counter width default
  localparam int COUNT_BITS_DEF = 32;

  // chunk offset width and its saturation value
  localparam int OFF_W = 33;
  localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};
  localparam logic [OFF_W-1:0] OFF_RESET = 33'd12;

  // magic words, bytes taken little endian
  localparam logic [31:0] MAGIC_RIFF = 32'h46464952;
  localparam logic [31:0] MAGIC_WAVE = 32'h45564157;
  localparam logic [31:0] MAGIC_FLAC = 32'h43614C66;
  localparam logic [31:0] MAGIC_DSD  = 32'h20445344;
  localparam logic [31:0] FMT_ID     = 32'h20746D66;

  // accepted wav format codes
  localparam logic [15:0] WAV_PCM        = 16'h0001;
  localparam logic [15:0] WAV_FLOAT      = 16'h0003;
  localparam logic [15:0] WAV_EXTENSIBLE = 16'hFFFE;

  // minimum lengths
  localparam int MAGIC_LEN = 12;
  localparam int WAV_MIN   = 44;
  localparam int FLAC_MIN  = 42;
  localparam int FMT_SPAN  = 24;

  // flac streaminfo byte range and first block type position
  localparam int FLAC_FIRST = 18;
  localparam int FLAC_LAST  = 25;
  localparam int BLOCK_TYPE_POS = 4;

  // stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 104;

  typedef enum logic [5:0] {
    PH_MAGIC = 6'b000001,
    PH_WALK  = 6'b000010,
    PH_FMT   = 6'b000100,
    PH_FLAC  = 6'b001000,
    PH_DSF   = 6'b010000,
    PH_UNK   = 6'b100000
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_SHORT        = 4'd1,
    ST_UNRECOGNISED = 4'd2,
    ST_WAV_SHORT    = 4'd3,
    ST_FMT_SHORT    = 4'd4,
    ST_BAD_CODE     = 4'd5,
    ST_NO_FMT       = 4'd6,
    ST_FLAC_SHORT   = 4'd7,
    ST_NOT_STREAMINFO = 4'd8,
    ST_FLAC_BAD     = 4'd9,
    ST_DSF_NOT_HANDLED = 4'd10
  } status_t;

  localparam logic [1:0] FT_UNKNOWN = 2'd0;
  localparam logic [1:0] FT_WAV     = 2'd1;
  localparam logic [1:0] FT_FLAC    = 2'd2;
  localparam logic [1:0] FT_DSF     = 2'd3;

  // one result item, file_type in the lowest bits
  typedef struct packed {
    logic [35:0] total_samples;
    logic [7:0]  bit_depth;
    logic [31:0] sample_rate;
    logic [15:0] channels;
    status_t     status;
    logic        is_valid;
    logic [1:0]  file_type;
  } result_t;

  // registered input item
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } in_item_t;

endpackage

### design/ahfp_in_stage.sv
`timescale 1ns / 1ps

module ahfp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               in_tlast,
  input  logic               take,
  output ahfp_pkg::in_item_t item
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       last_r;

  // room when empty or when the held byte moves on this cycle
  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign item.valid = valid_r;
  assign item.last  = last_r;
  assign item.data  = data_r;

endmodule

### design/ahfp_parser.sv
`timescale 1ns / 1ps

module ahfp_parser #(
  parameter int COUNT_BITS = ahfp_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ahfp_pkg::in_item_t  item,
  input  logic                out_room,
  output logic                take,
  output logic                emit,
  output ahfp_pkg::result_t   result
);

  // compare width covering both the byte index and offsets plus a margin
  localparam int IW = (COUNT_BITS > ahfp_pkg::OFF_W + 1) ? COUNT_BITS + 1
                                                         : ahfp_pkg::OFF_W + 2;

  logic [COUNT_BITS-1:0]     count_r, count_nxt;
  logic [87:0]               win_r, win_nxt;
  ahfp_pkg::phase_t          phase_r, phase_nxt;
  logic [ahfp_pkg::OFF_W-1:0] off_r, off_nxt;
  logic [63:0]               chdr_r, chdr_nxt;
  logic [15:0]               fcode_r, fcode_nxt;
  logic [15:0]               chan_r, chan_nxt;
  logic [31:0]               rate_r, rate_nxt;
  logic [7:0]                depth_r, depth_nxt;
  logic [6:0]                btype_r, btype_nxt;

  logic                      active;
  logic [7:0]                b;
  logic                      in_magic;
  logic [IW-1:0]             idx_w, off_w, walk_diff, fmt_base, fmt_diff;
  logic                      walk_hit, fmt_hit;
  logic [2:0]                k;
  logic [3:0]                rel;
  logic [31:0]               csize;
  logic [ahfp_pkg::OFF_W:0]  np;
  logic [31:0]               word0, word2;
  logic [COUNT_BITS-1:0]     len;
  logic [31:0]               fword;
  logic [19:0]               flac_rate;

  assign b      = item.data;
  // unmarked bytes never need the output slot
  assign take   = item.valid && (out_room || !item.last);
  assign emit   = take && item.last;
  assign active = !(&count_r);
  assign in_magic = count_r < COUNT_BITS'(ahfp_pkg::MAGIC_LEN);

  // window arithmetic for chunk walk and fmt body
  assign idx_w     = IW'(count_r);
  assign off_w     = IW'(off_r);
  assign walk_diff = idx_w - off_w;
  assign walk_hit  = (off_r != ahfp_pkg::OFF_MAX) && (idx_w >= off_w) &&
                     (walk_diff < IW'(8));
  assign k         = walk_diff[2:0];
  assign fmt_base  = off_w + IW'(8);
  assign fmt_diff  = idx_w - fmt_base;
  assign fmt_hit   = (idx_w >= fmt_base) && (fmt_diff < IW'(16));
  assign rel       = fmt_diff[3:0];

  // next chunk offset when a chunk is skipped
  assign csize = {b, chdr_r[55:32]};
  assign np    = {1'b0, off_r} + (ahfp_pkg::OFF_W + 1)'(8) +
                 (ahfp_pkg::OFF_W + 1)'(csize) + (ahfp_pkg::OFF_W + 1)'(csize[0]);

  assign word0 = win_r[31:0];
  assign word2 = {b, win_r[87:64]};

  // per-byte state update
  always_comb begin
    count_nxt = count_r;
    win_nxt   = win_r;
    phase_nxt = phase_r;
    off_nxt   = off_r;
    chdr_nxt  = chdr_r;
    fcode_nxt = fcode_r;
    chan_nxt  = chan_r;
    rate_nxt  = rate_r;
    depth_nxt = depth_r;
    btype_nxt = btype_r;
    if (active) begin
      count_nxt = count_r + COUNT_BITS'(1);
      if (in_magic) begin
        for (int i = 0; i < 11; i++) begin
          if (count_r[3:0] == 4'(i)) begin
            win_nxt[8*i +: 8] = b;
          end
        end
        if (count_r[3:0] == 4'(ahfp_pkg::BLOCK_TYPE_POS)) begin
          btype_nxt = b[6:0];
        end
        if (count_r[3:0] == 4'd11) begin
          if (word0 == ahfp_pkg::MAGIC_RIFF && word2 == ahfp_pkg::MAGIC_WAVE) begin
            phase_nxt = ahfp_pkg::PH_WALK;
          end else if (word0 == ahfp_pkg::MAGIC_FLAC) begin
            phase_nxt = ahfp_pkg::PH_FLAC;
          end else if (word0 == ahfp_pkg::MAGIC_DSD) begin
            phase_nxt = ahfp_pkg::PH_DSF;
          end else begin
            phase_nxt = ahfp_pkg::PH_UNK;
          end
        end
      end else begin
        case (phase_r)
          ahfp_pkg::PH_WALK: begin
            if (walk_hit) begin
              chdr_nxt[8*k +: 8] = b;
              if (k == 3'd7) begin
                if (chdr_r[31:0] == ahfp_pkg::FMT_ID) begin
                  phase_nxt = ahfp_pkg::PH_FMT;
                end else if (np > {1'b0, ahfp_pkg::OFF_MAX}) begin
                  off_nxt = ahfp_pkg::OFF_MAX;
                end else begin
                  off_nxt = np[ahfp_pkg::OFF_W-1:0];
                end
              end
            end
          end
          ahfp_pkg::PH_FMT: begin
            if (fmt_hit) begin
              if (rel < 4'd2) begin
                fcode_nxt[8*rel[0] +: 8] = b;
              end else if (rel < 4'd4) begin
                chan_nxt[8*rel[0] +: 8] = b;
              end else if (rel < 4'd8) begin
                rate_nxt[8*rel[1:0] +: 8] = b;
              end else if (rel == 4'd14) begin
                depth_nxt = b;
              end
            end
          end
          ahfp_pkg::PH_FLAC: begin
            if (count_r >= COUNT_BITS'(ahfp_pkg::FLAC_FIRST) &&
                count_r <= COUNT_BITS'(ahfp_pkg::FLAC_LAST)) begin
              chdr_nxt = {chdr_r[55:0], b};
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result from the updated state
  assign len       = count_nxt;
  assign fword     = chdr_nxt[63:32];
  assign flac_rate = fword[31:12];

  always_comb begin
    result = '0;
    result.status = ahfp_pkg::ST_OK;
    if (len < COUNT_BITS'(ahfp_pkg::MAGIC_LEN)) begin
      result.status = ahfp_pkg::ST_SHORT;
    end else begin
      case (phase_nxt)
        ahfp_pkg::PH_WALK, ahfp_pkg::PH_FMT: begin
          result.file_type = ahfp_pkg::FT_WAV;
          if (len < COUNT_BITS'(ahfp_pkg::WAV_MIN)) begin
            result.status = ahfp_pkg::ST_WAV_SHORT;
          end else if (phase_nxt != ahfp_pkg::PH_FMT) begin
            result.status = ahfp_pkg::ST_NO_FMT;
          end else if (IW'(len) < off_w + IW'(ahfp_pkg::FMT_SPAN)) begin
            result.status = ahfp_pkg::ST_FMT_SHORT;
          end else begin
            result.channels    = chan_nxt;
            result.sample_rate = rate_nxt;
            result.bit_depth   = depth_nxt;
            if (fcode_nxt == ahfp_pkg::WAV_PCM || fcode_nxt == ahfp_pkg::WAV_FLOAT ||
                fcode_nxt == ahfp_pkg::WAV_EXTENSIBLE) begin
              result.is_valid = 1'b1;
            end else begin
              result.status = ahfp_pkg::ST_BAD_CODE;
            end
          end
        end
        ahfp_pkg::PH_FLAC: begin
          result.file_type = ahfp_pkg::FT_FLAC;
          if (len < COUNT_BITS'(ahfp_pkg::FLAC_MIN)) begin
            result.status = ahfp_pkg::ST_FLAC_SHORT;
          end else if (btype_nxt != 7'd0) begin
            result.status = ahfp_pkg::ST_NOT_STREAMINFO;
          end else begin
            result.sample_rate   = 32'(flac_rate);
            result.channels      = 16'(fword[11:9]) + 16'd1;
            result.bit_depth     = 8'(fword[8:4]) + 8'd1;
            result.total_samples = {fword[3:0], chdr_nxt[31:0]};
            if (flac_rate != 20'd0) begin
              result.is_valid = 1'b1;
            end else begin
              result.status = ahfp_pkg::ST_FLAC_BAD;
            end
          end
        end
        ahfp_pkg::PH_DSF: begin
          result.file_type = ahfp_pkg::FT_DSF;
          result.status    = ahfp_pkg::ST_DSF_NOT_HANDLED;
          result.bit_depth = 8'd1;
        end
        default: begin
          result.status = ahfp_pkg::ST_UNRECOGNISED;
        end
      endcase
    end
  end

  // state registers, back to reset values after each marked byte
  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      count_r <= '0;
      win_r   <= '0;
      phase_r <= ahfp_pkg::PH_MAGIC;
      off_r   <= ahfp_pkg::OFF_RESET;
      chdr_r  <= '0;
      fcode_r <= '0;
      chan_r  <= '0;
      rate_r  <= '0;
      depth_r <= '0;
      btype_r <= '0;
    end else if (take) begin
      count_r <= count_nxt;
      win_r   <= win_nxt;
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      chdr_r  <= chdr_nxt;
      fcode_r <= fcode_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      depth_r <= depth_nxt;
      btype_r <= btype_nxt;
    end
  end

endmodule

### design/ahfp_out_stage.sv
`timescale 1ns / 1ps

module ahfp_out_stage (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 emit,
  input  ahfp_pkg::result_t                    result,
  output logic                                 out_room,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ahfp_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int RES_W = $bits(ahfp_pkg::result_t);

  logic              valid_r, valid_nxt;
  ahfp_pkg::result_t res_r;

  // free when empty or when the held result transfers now
  assign out_room = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (emit) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(ahfp_pkg::OUT_TDATA_W - RES_W){1'b0}}, res_r};

endmodule

### design/audio_header_format_parser_top.sv
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                           | tlast
// in_     | in  | data_byte[7:0]                               | last_byte
// out_    | out | file_type, is_valid, status, channels,       | -
//         |     | sample_rate, bit_depth, total_samples, pad   |
//
// one header byte per cycle; a byte is registered, parsed, and on the marked
// byte the result is captured in the output register as that byte is taken
// the byte parse (compare, chunk offset add, field capture) is a single pass
// rst_n clears the byte counter, parse phase and both handshake stages
// a stalled output only holds the input side when a marked byte needs the slot

module audio_header_format_parser_top #(
  parameter int COUNT_BITS = ahfp_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ahfp_pkg::IN_TDATA_W-1:0]   in_tdata,   // data_byte
  input  logic                              in_tlast,   // last_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // file_type, is_valid, status, channels, sample_rate, bit_depth,
  // total_samples, zero pad
  output logic [ahfp_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  ahfp_pkg::in_item_t item;
  ahfp_pkg::result_t  result;
  logic               take;
  logic               emit;
  logic               out_room;

  ahfp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .take      (take),
    .item      (item)
  );

  ahfp_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (item),
    .out_room (out_room),
    .take     (take),
    .emit     (emit),
    .result   (result)
  );

  ahfp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .result     (result),
    .out_room   (out_room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### design/ahfp_checker.sv
`timescale 1ns / 1ps
`include "audio_header_format_parser_top_defines.svh"

module ahfp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ahfp_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic [1:0] ftype;
  logic       vld;
  logic [3:0] stat;

  assign ftype = out_tdata[1:0];
  assign vld   = out_tdata[2];
  assign stat  = out_tdata[6:3];

  // stalled result stays put
  `AHFP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // valid flag goes with the ok status only
  `AHFP_ASSERT_NOW(a_valid_ok, out_tvalid, vld == (stat == ahfp_pkg::ST_OK), "valid flag and status disagree")

  // unknown type only for short or unrecognised buffers
  `AHFP_ASSERT_NOW(a_unknown_status, out_tvalid && ftype == ahfp_pkg::FT_UNKNOWN, stat == ahfp_pkg::ST_SHORT || stat == ahfp_pkg::ST_UNRECOGNISED, "unknown type with wrong status")

  // pad bits above the result are zero
  `AHFP_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[ahfp_pkg::OUT_TDATA_W-1:99] == '0, "pad bits set")

endmodule

bind audio_header_format_parser_top ahfp_checker u_ahfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### verif/audio_header_format_parser_checker.sv
`timescale 1ns / 1ps

// watches both channels, predicts each header result and compares it
module audio_header_format_parser_checker
  import ahfp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte
  input  logic                   in_tlast,   // last_byte
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // file_type, is_valid, status, channels, sample_rate, bit_depth,
  // total_samples, zero pad
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int unsigned            fail_count,
  output int unsigned            outstanding
);

  localparam logic [63:0] CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

  // parser state mirrored from the block
  logic [63:0] n_bytes;
  logic [7:0]  magic_win [MAGIC_LEN];
  phase_t      phase;
  logic [63:0] chunk_at;
  logic [63:0] chunk_hdr;
  logic        fmt_seen;
  logic [15:0] wav_code;
  logic [15:0] wav_chans;
  logic [31:0] wav_rate;
  logic [7:0]  wav_depth;
  logic [6:0]  flac_block;

  result_t expected_results [$];

  function automatic void clear_parse_state();
    n_bytes = '0;
    foreach (magic_win[i]) magic_win[i] = '0;
    phase = PH_MAGIC;
    chunk_at = 64'(OFF_RESET);
    chunk_hdr = '0;
    fmt_seen = 1'b0;
    wav_code = '0;
    wav_chans = '0;
    wav_rate = '0;
    wav_depth = '0;
    flac_block = '0;
  endfunction

  // four window bytes read as a little-endian word
  function automatic logic [31:0] window_word(input int at);
    return {magic_win[at+3], magic_win[at+2], magic_win[at+1], magic_win[at]};
  endfunction

  function automatic void take_byte(input logic [63:0] idx, input logic [7:0] b);
    logic [63:0] at;
    logic [63:0] next_at;
    logic [31:0] size;
    int          rel;
    // magic window, type decided on its final byte
    if (idx < MAGIC_LEN) begin
      magic_win[int'(idx)] = b;
      if (idx == BLOCK_TYPE_POS) flac_block = b[6:0];
      if (idx == MAGIC_LEN - 1) begin
        if (window_word(0) == MAGIC_RIFF && window_word(8) == MAGIC_WAVE) phase = PH_WALK;
        else if (window_word(0) == MAGIC_FLAC) phase = PH_FLAC;
        else if (window_word(0) == MAGIC_DSD) phase = PH_DSF;
        else phase = PH_UNK;
      end
      return;
    end
    case (phase)
      // chunk walk: gather the 8-byte header, then skip or enter fmt
      PH_WALK: begin
        at = chunk_at;
        if (at < OFF_MAX && idx >= at && idx < at + 64'd8) begin
          rel = int'(idx - at);
          if (rel == 0) chunk_hdr = '0;
          chunk_hdr[8*rel +: 8] = b;
          if (rel == 7) begin
            size = chunk_hdr[63:32];
            if (chunk_hdr[31:0] == FMT_ID) begin
              fmt_seen = 1'b1;
              phase = PH_FMT;
            end else begin
              next_at = at + 64'd8 + {32'd0, size} + {63'd0, size[0]};
              chunk_at = (next_at > OFF_MAX) ? 64'(OFF_MAX) : next_at;
            end
          end
        end
      end
      // fmt body: code, channels, rate, low byte of depth
      PH_FMT: begin
        at = chunk_at + 64'd8;
        if (idx >= at && idx - at < 64'd16) begin
          rel = int'(idx - at);
          if (rel < 2) wav_code[8*rel +: 8] = b;
          else if (rel < 4) wav_chans[8*(rel-2) +: 8] = b;
          else if (rel < 8) wav_rate[8*(rel-4) +: 8] = b;
          else if (rel == 14) wav_depth = b;
        end
      end
      // streaminfo bytes shifted in big-endian
      PH_FLAC: begin
        if (idx >= FLAC_FIRST && idx <= FLAC_LAST) chunk_hdr = {chunk_hdr[55:0], b};
      end
      default: ;
    endcase
  endfunction

  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    result_t     r;
    logic [63:0] len;
    logic [31:0] word;
    if (n_bytes < CNT_MAX) begin
      take_byte(n_bytes, b);
      n_bytes = n_bytes + 64'd1;
    end
    if (!last) return;
    r = '0;
    len = n_bytes;
    if (len < MAGIC_LEN) begin
      r.status = ST_SHORT;
    end else if (phase == PH_WALK || phase == PH_FMT) begin
      r.file_type = FT_WAV;
      if (len < WAV_MIN) r.status = ST_WAV_SHORT;
      else if (!fmt_seen) r.status = ST_NO_FMT;
      else if (len < chunk_at + FMT_SPAN) r.status = ST_FMT_SHORT;
      else begin
        r.channels = wav_chans;
        r.sample_rate = wav_rate;
        r.bit_depth = wav_depth;
        if (wav_code inside {WAV_PCM, WAV_FLOAT, WAV_EXTENSIBLE}) r.is_valid = 1'b1;
        else r.status = ST_BAD_CODE;
      end
    end else if (phase == PH_FLAC) begin
      r.file_type = FT_FLAC;
      if (len < FLAC_MIN) r.status = ST_FLAC_SHORT;
      else if (flac_block != '0) r.status = ST_NOT_STREAMINFO;
      else begin
        // channels and depth are stored minus one
        word = chunk_hdr[63:32];
        r.sample_rate = {12'd0, word[31:12]};
        r.channels = {13'd0, word[11:9]} + 16'd1;
        r.bit_depth = {3'd0, word[8:4]} + 8'd1;
        r.total_samples = {word[3:0], chunk_hdr[31:0]};
        if (word[31:12] != '0) r.is_valid = 1'b1;
        else r.status = ST_FLAC_BAD;
      end
    end else if (phase == PH_DSF) begin
      r.file_type = FT_DSF;
      r.status = ST_DSF_NOT_HANDLED;
      r.bit_depth = 8'd1;
    end else begin
      r.status = ST_UNRECOGNISED;
    end
    expected_results.push_back(r);
    clear_parse_state();
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count = fail_count + 1;
    end
  endfunction

  // input transfers feed the predictor, output transfers are compared in order
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst_n) begin
      clear_parse_state();
      expected_results.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (in_tvalid && in_tready) absorb_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        seen = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, seen);
          fail_count = fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          check_field("file_type", 64'(want.file_type), 64'(seen.file_type));
          check_field("is_valid", 64'(want.is_valid), 64'(seen.is_valid));
          check_field("status", 64'(want.status), 64'(seen.status));
          check_field("channels", 64'(want.channels), 64'(seen.channels));
          check_field("sample_rate", 64'(want.sample_rate), 64'(seen.sample_rate));
          check_field("bit_depth", 64'(want.bit_depth), 64'(seen.bit_depth));
          check_field("total_samples", 64'(want.total_samples), 64'(seen.total_samples));
        end
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

### verif/audio_header_format_parser_top_test.sv
`timescale 1ns / 1ps

module audio_header_format_parser_top_test;
  import ahfp_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // data_byte
  logic                   in_tlast;   // last_byte
  logic                   out_tvalid;
  logic                   out_tready;
  // file_type, is_valid, status, channels, sample_rate, bit_depth,
  // total_samples, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  int unsigned            fail_count;
  int unsigned            outstanding;

  logic [7:0]  header_bytes [$];
  int unsigned bytes_sent;
  int unsigned buffers_sent;
  bit          steady;

  always #10 clk = ~clk;

  audio_header_format_parser_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  audio_header_format_parser_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // header assembly helpers
  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) header_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic put_rand(input int n);
    for (int i = 0; i < n; i++) header_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_fill(input logic [7:0] v, input int n);
    for (int i = 0; i < n; i++) header_bytes.push_back(v);
  endtask

  task automatic cut_to(input int n);
    while (header_bytes.size() > n) void'(header_bytes.pop_back());
  endtask

  // riff/wave, optional junk chunk (negative size for none), fmt chunk, tail
  task automatic build_wav(input logic [15:0] code, input logic [15:0] chans,
                           input logic [31:0] rate, input logic [15:0] depth,
                           input int junk, input int tail);
    put_le(MAGIC_RIFF, 4);
    put_rand(4);
    put_le(MAGIC_WAVE, 4);
    if (junk >= 0) begin
      put_le(32'h4B4E554A, 4);
      put_le(junk, 4);
      put_rand(junk + (junk % 2));
    end
    put_le(FMT_ID, 4);
    put_le(32'd16, 4);
    put_le(code, 2);
    put_le(chans, 2);
    put_le(rate, 4);
    put_rand(6);
    put_le(depth, 2);
    put_rand(tail);
  endtask

  // flac magic, block header byte, streaminfo with bytes 18..25 given
  task automatic build_flac(input logic [7:0] blk, input logic [63:0] info, input int extra);
    put_le(MAGIC_FLAC, 4);
    header_bytes.push_back(blk);
    put_rand(13);
    for (int i = 7; i >= 0; i--) header_bytes.push_back(info[8*i +: 8]);
    put_rand(16 + extra);
  endtask

  task automatic random_wav();
    logic [15:0] code;
    case ($urandom_range(0, 3))
      0: code = WAV_PCM;
      1: code = WAV_FLOAT;
      2: code = WAV_EXTENSIBLE;
      default: code = 16'($urandom);
    endcase
    build_wav(code, 16'($urandom), $urandom, 16'($urandom),
              ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, 13),
              $urandom_range(0, 16));
  endtask

  // chunks that are never fmt, some far too large to walk past
  task automatic random_wav_without_fmt();
    logic [31:0] id;
    logic [31:0] size;
    put_le(MAGIC_RIFF, 4);
    put_rand(4);
    put_le(MAGIC_WAVE, 4);
    for (int i = 0; i < $urandom_range(1, 3); i++) begin
      id = $urandom;
      if (id == FMT_ID) id = ~id;
      size = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 20);
      put_le(id, 4);
      put_le(size, 4);
      if (size > 20) begin
        put_rand($urandom_range(0, 30));
        break;
      end
      put_rand(size + size[0]);
    end
    put_rand($urandom_range(0, 10));
  endtask

  task automatic random_flac();
    logic [7:0]  blk;
    logic [63:0] info;
    case ($urandom_range(0, 3))
      0, 1: blk = 8'h00;
      2: blk = 8'h80;
      default: blk = 8'($urandom);
    endcase
    info = {$urandom, $urandom};
    if ($urandom_range(0, 4) == 0) info[63:44] = '0;
    build_flac(blk, info, $urandom_range(0, 8));
  endtask

  // one byte transfer after a random gap, or none in a steady stretch
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_buffer();
    steady = ($urandom_range(0, 5) == 0);
    foreach (header_bytes[i]) begin
      push_byte(header_bytes[i], i == header_bytes.size() - 1);
      bytes_sent++;
    end
    buffers_sent++;
    header_bytes.delete();
  endtask

  // hold off the sender until every predicted result has come out
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // result side: random stall before each transfer
  initial begin
    int stall;
    out_tready <= 1'b0;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // stimulus
  initial begin
    int unsigned pick;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    bytes_sent = 0;
    buffers_sent = 0;
    steady = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short buffers: a single byte, then eleven all-ones bytes
    header_bytes.push_back(8'h00);
    send_buffer();
    put_fill(8'hFF, 11);
    send_buffer();
    // riff with a non-wave form type
    put_le(MAGIC_RIFF, 4);
    put_le(32'd0, 4);
    put_le(32'h20495641, 4);
    send_buffer();
    // plain pcm at exactly the minimum wav length
    build_wav(WAV_PCM, 16'd2, 32'd44100, 16'd16, -1, 8);
    send_buffer();
    // float with every field at its top value
    build_wav(WAV_FLOAT, 16'hFFFF, 32'hFFFF_FFFF, 16'h00FF, -1, 8);
    send_buffer();
    // extensible behind a junk chunk of odd size, zero fields
    build_wav(WAV_EXTENSIBLE, 16'd0, 32'd0, 16'd0, 3, 0);
    send_buffer();
    // unsupported format code behind an empty chunk
    build_wav(16'h0002, 16'd1, 32'd8000, 16'd8, 0, 8);
    send_buffer();
    // wav one byte under the minimum
    build_wav(WAV_PCM, 16'd2, 32'd48000, 16'd24, -1, 8);
    cut_to(WAV_MIN - 1);
    send_buffer();
    // wav with no fmt chunk at all
    put_le(MAGIC_RIFF, 4);
    put_rand(4);
    put_le(MAGIC_WAVE, 4);
    put_le(32'h5453494C, 4);
    put_le(32'd40, 4);
    put_rand(40);
    send_buffer();
    // fmt chunk found late, body cut short
    build_wav(WAV_PCM, 16'd2, 32'd96000, 16'd32, 30, 0);
    cut_to(62);
    send_buffer();
    // maximum chunk size, walk cannot reach another header
    put_le(MAGIC_RIFF, 4);
    put_rand(4);
    put_le(MAGIC_WAVE, 4);
    put_le(32'h4B4E554A, 4);
    put_le(32'hFFFF_FFFF, 4);
    put_rand(40);
    send_buffer();
    // flac streaminfo 48 kHz stereo 24 bit
    build_flac(8'h00, {20'd48000, 3'd1, 5'd23, 36'd1234567}, 0);
    send_buffer();
    // flac with last-block flag and all-ones streaminfo
    build_flac(8'h80, '1, 4);
    send_buffer();
    // flac with zero rate and all-zero streaminfo
    build_flac(8'h00, '0, 0);
    send_buffer();
    // flac whose first block is not streaminfo
    build_flac(8'hFF, {$urandom, $urandom}, 0);
    send_buffer();
    // flac one byte under the minimum, and just the magic window
    build_flac(8'h00, {$urandom, $urandom}, 0);
    cut_to(FLAC_MIN - 1);
    send_buffer();
    build_flac(8'h00, {$urandom, $urandom}, 0);
    cut_to(MAGIC_LEN);
    send_buffer();
    // dsf recognised by magic only
    put_le(MAGIC_DSD, 4);
    put_rand(24);
    send_buffer();
    wait_results_drained();

    // random headers, mostly well formed with random content
    while (bytes_sent < 1300 || buffers_sent < 30) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) put_rand($urandom_range(1, 24));
      else if (pick < 45) random_wav();
      else if (pick < 55) random_wav_without_fmt();
      else if (pick < 80) random_flac();
      else if (pick < 88) begin
        put_le(MAGIC_DSD, 4);
        put_rand($urandom_range(0, 40));
      end else begin
        // broken magic
        if ($urandom_range(0, 1) == 0) random_flac();
        else random_wav();
        header_bytes[$urandom_range(0, MAGIC_LEN - 1)] ^= 8'($urandom_range(1, 255));
      end
      if ($urandom_range(0, 4) == 0) cut_to($urandom_range(1, header_bytes.size()));
      send_buffer();
      if ($urandom_range(0, 29) == 0) wait_results_drained();
    end

    wait_results_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
